/* src/track_connection_tuple_parser_core_macros.svh */
// ----------------------------------------------------------------------------
// Track connection tuple parser - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef TRACK_CONNECTION_TUPLE_PARSER_CORE_MACROS_SVH
`define TRACK_CONNECTION_TUPLE_PARSER_CORE_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define TCP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define TCP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define TCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/tcp_pkg.sv */
// ----------------------------------------------------------------------------
// tcp_pkg
// Types, character codes and helpers for the track connection tuple parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tcp_pkg;

    localparam int NUMBER_WIDTH_DEF = 16;
    localparam int OUT_WIDTH        = 16;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HT     = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_UP_W   = 8'h57;
    localparam logic [7:0] CH_LO_W   = 8'h77;
    localparam logic [7:0] CASE_DIFF = 8'h20;

    localparam logic [1:0] SIDE_WEST    = 2'd0;
    localparam logic [1:0] SIDE_EAST    = 2'd1;
    localparam logic [1:0] SIDE_NONE    = 2'd2;
    localparam logic [1:0] SIDE_INVALID = 2'd3;

    // Register index of default_side
    localparam logic REG_DEFAULT_SIDE = 1'b0;

    typedef enum logic [3:0] {
        SEC_OUTSIDE    = 4'd0,
        SEC_LETTER     = 4'd1,
        SEC_GATE_PRE   = 4'd2,
        SEC_GATE_NUM   = 4'd3,
        SEC_STN_PRE    = 4'd4,
        SEC_STN_NUM    = 4'd5,
        SEC_STN_COMMA  = 4'd6,
        SEC_SIDE       = 4'd7,
        SEC_AFTER_SIDE = 4'd8
    } t_section;

    typedef struct packed {
        logic [7:0]           gate_letter;
        logic [OUT_WIDTH-1:0] gate_track;
        logic [OUT_WIDTH-1:0] station_track;
        logic [1:0]           track_side;
        logic                 number_saturated;
    } t_result;

    function automatic logic is_skip(input logic [7:0] c);
        is_skip = (c == CH_SPACE) || (c == CH_COMMA) || ((c >= CH_HT) && (c <= CH_CR));
    endfunction

    function automatic logic [1:0] side_of(input logic [7:0] c);
        if ((c == CH_UP_E) || (c == CH_LO_E)) begin
            side_of = SIDE_EAST;
        end else if ((c == CH_UP_W) || (c == CH_LO_W)) begin
            side_of = SIDE_WEST;
        end else begin
            side_of = SIDE_NONE;
        end
    endfunction

endpackage

`default_nettype wire

/* src/tcp_cfg.sv */
// ----------------------------------------------------------------------------
// tcp_cfg
// APB-style register file holding default_side; out-of-range writes clamp to none.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_cfg import tcp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [1:0]  o_default_side
);

    logic [1:0] r_default_side;
    logic [1:0] n_default_side;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_DEFAULT_SIDE);

    always_comb begin
        n_default_side = r_default_side;
        if (wr_en) begin
            n_default_side = (pwdata[1:0] == SIDE_INVALID) ? SIDE_NONE : pwdata[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_side <= SIDE_NONE;
        end else begin
            r_default_side <= n_default_side;
        end
    end

    // byte offset bits of paddr are don't-care
    assign prdata = (paddr[2] == REG_DEFAULT_SIDE) ? {30'd0, r_default_side} : 32'd0;
    assign o_default_side = r_default_side;

endmodule

`default_nettype wire

/* src/tcp_parse.sv */
// ----------------------------------------------------------------------------
// tcp_parse
// Parse state registers and the one-character update step.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_parse import tcp_pkg::*; #(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_char,
    input  wire logic       i_sov,
    input  wire logic [1:0] i_default_side,
    output logic            o_res_valid,
    output t_result         o_res
);

    localparam int NW = NUMBER_WIDTH;
    localparam int MW = NW + 4;
    localparam logic [MW-1:0] NUM_MAX = {4'd0, {NW{1'b1}}};

    t_section        r_sec;
    logic [NW-1:0]   r_acc;
    logic [7:0]      r_letter;
    logic [NW-1:0]   r_gtrack;
    logic [1:0]      r_side;
    logic            r_sat;

    t_section        n_sec;
    logic [NW-1:0]   n_acc;
    logic [7:0]      n_letter;
    logic [NW-1:0]   n_gtrack;
    logic [1:0]      n_side;
    logic            n_sat;
    logic            n_emit;

    // state as seen after an optional start-of-value reset
    t_section        s_sec;
    logic [NW-1:0]   s_acc;
    logic [7:0]      s_letter;
    logic [NW-1:0]   s_gtrack;
    logic [1:0]      s_side;
    logic            s_sat;

    logic            is_digit;
    logic            is_term;
    logic            skip;
    logic [NW-1:0]   num_base;
    logic [MW-1:0]   prod;
    logic [NW-1:0]   num_next;
    logic            num_clamp;
    logic [NW+15:0]  gtrack_ext;
    logic [NW+15:0]  acc_ext;

    always_comb begin
        is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        is_term  = (i_char == CH_COMMA) || (i_char == CH_RPAREN);
        skip     = is_skip(i_char);

        if (i_sov) begin
            s_sec    = SEC_OUTSIDE;
            s_acc    = '0;
            s_letter = 8'd0;
            s_gtrack = '0;
            s_side   = i_default_side;
            s_sat    = 1'b0;
        end else begin
            s_sec    = r_sec;
            s_acc    = r_acc;
            s_letter = r_letter;
            s_gtrack = r_gtrack;
            s_side   = r_side;
            s_sat    = r_sat;
        end

        // a number restarts from zero on its first character
        num_base  = ((s_sec == SEC_GATE_PRE) || (s_sec == SEC_STN_PRE)) ? '0 : s_acc;
        prod      = ({num_base, 3'b000} + {3'b000, num_base, 1'b0})
                    + {{(MW-4){1'b0}}, i_char[3:0]};
        num_clamp = prod > NUM_MAX;
        num_next  = num_clamp ? {NW{1'b1}} : prod[NW-1:0];

        n_sec    = s_sec;
        n_acc    = s_acc;
        n_letter = s_letter;
        n_gtrack = s_gtrack;
        n_side   = s_side;
        n_sat    = s_sat;
        n_emit   = 1'b0;

        case (s_sec)
            SEC_OUTSIDE: begin
                if (i_char == CH_LPAREN) begin
                    n_sat = 1'b0;
                    n_sec = SEC_LETTER;
                end
            end
            SEC_LETTER: begin
                if ((i_char >= CH_UP_A) && (i_char <= CH_UP_Z)) begin
                    n_letter = i_char;
                    n_sec    = SEC_GATE_PRE;
                end else if ((i_char >= CH_LO_A) && (i_char <= CH_LO_Z)) begin
                    n_letter = i_char - CASE_DIFF;
                    n_sec    = SEC_GATE_PRE;
                end
            end
            SEC_GATE_PRE, SEC_GATE_NUM: begin
                if (!((s_sec == SEC_GATE_PRE) && skip)) begin
                    n_acc = num_base;
                    n_sec = SEC_GATE_NUM;
                    if (is_digit) begin
                        n_acc = num_next;
                        if (num_clamp) begin
                            n_sat = 1'b1;
                        end
                    end else if (is_term) begin
                        n_gtrack = num_base;
                        n_sec    = SEC_STN_PRE;
                    end
                end
            end
            SEC_STN_PRE, SEC_STN_NUM: begin
                if (!((s_sec == SEC_STN_PRE) && skip)) begin
                    n_acc = num_base;
                    n_sec = SEC_STN_NUM;
                    if (is_digit) begin
                        n_acc = num_next;
                        if (num_clamp) begin
                            n_sat = 1'b1;
                        end
                    end else if (i_char == CH_RPAREN) begin
                        n_emit = 1'b1;
                        n_sec  = SEC_OUTSIDE;
                    end else if (i_char == CH_COMMA) begin
                        n_sec = SEC_STN_COMMA;
                    end
                end
            end
            SEC_STN_COMMA: begin
                if (!skip) begin
                    if (i_char == CH_RPAREN) begin
                        n_emit = 1'b1;
                        n_sec  = SEC_OUTSIDE;
                    end else begin
                        n_side = side_of(i_char);
                        n_sec  = SEC_AFTER_SIDE;
                    end
                end
            end
            SEC_SIDE: begin
                if (!skip) begin
                    n_side = side_of(i_char);
                    n_sec  = SEC_AFTER_SIDE;
                end
            end
            SEC_AFTER_SIDE: begin
                // one non-skip character after the side is dropped unless it closes
                if (!skip) begin
                    if (i_char == CH_RPAREN) begin
                        n_emit = 1'b1;
                        n_sec  = SEC_OUTSIDE;
                    end else begin
                        n_sec = SEC_SIDE;
                    end
                end
            end
            default: begin
                n_sec = SEC_OUTSIDE;
            end
        endcase

        gtrack_ext = {16'd0, n_gtrack};
        acc_ext    = {16'd0, n_acc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec    <= SEC_OUTSIDE;
            r_acc    <= '0;
            r_letter <= 8'd0;
            r_gtrack <= '0;
            r_side   <= SIDE_NONE;
            r_sat    <= 1'b0;
        end else if (i_fire) begin
            r_sec    <= n_sec;
            r_acc    <= n_acc;
            r_letter <= n_letter;
            r_gtrack <= n_gtrack;
            r_side   <= n_side;
            r_sat    <= n_sat;
        end
    end

    assign o_res_valid = n_emit;

    always_comb begin
        o_res.gate_letter      = n_letter;
        o_res.gate_track       = gtrack_ext[OUT_WIDTH-1:0];
        o_res.station_track    = acc_ext[OUT_WIDTH-1:0];
        o_res.track_side       = n_side;
        o_res.number_saturated = n_sat;
    end

endmodule

`default_nettype wire

/* src/track_connection_tuple_parser_core.sv */
// ----------------------------------------------------------------------------
// track_connection_tuple_parser_core
// Streams tuple text "(letter,number,number[,side])" and emits one record per
// closed tuple.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle unless the input stalls. A character
// lands in the input register, the combinational parse step updates the tuple
// state and, when a tuple closes, loads the result register, whose record is
// valid on the output once the step has fired on its closing character. The
// input side keeps accepting while a record waits at the output; it stalls
// only when the held character would close a tuple and the result register is
// occupied and stalled. default_side is written over the APB port at byte
// address 0 and applies at the next start of a value.
`default_nettype none

`include "track_connection_tuple_parser_core_macros.svh"

module track_connection_tuple_parser_core import tcp_pkg::*; #(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_character,
    input  wire logic        i_start_of_value,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [7:0]  o_gate_letter,
    output logic      [15:0] o_gate_track,
    output logic      [15:0] o_station_track,
    output logic      [1:0]  o_track_side,
    output logic             o_number_saturated,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_sov;
    logic       r_out_valid;
    t_result    r_res;

    logic       in_accept;
    logic       out_free;
    logic       fire;
    logic       res_valid;
    t_result    res;
    logic [1:0] default_side;

    tcp_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_default_side (default_side)
    );

    tcp_parse #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_char         (r_char),
        .i_sov          (r_sov),
        .i_default_side (default_side),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    // a character that produces no record never waits on the output
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && (!res_valid || out_free);
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_char <= i_character;
            r_sov  <= i_start_of_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_res <= res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_gate_letter      = r_res.gate_letter;
    assign o_gate_track       = r_res.gate_track;
    assign o_station_track    = r_res.station_track;
    assign o_track_side       = r_res.track_side;
    assign o_number_saturated = r_res.number_saturated;

    `TCP_ASSERT_IMP(a_no_overwrite, r_out_valid && i_out_stall, !(fire && res_valid))
    `TCP_ASSERT_IMP(a_side_legal, r_out_valid, o_track_side != SIDE_INVALID)
    `TCP_ASSERT_ALWAYS(a_default_legal, default_side != SIDE_INVALID)
    `TCP_ASSERT_NEXT(a_record_loaded, fire && res_valid, r_out_valid)

endmodule

`default_nettype wire
